@@ hw/rtl/ckhc_pkg.sv @@
// Shared types and constants for the canonical k-mer haplotype counter.
// No dependencies; imported by the queue, front, back and top-level files.
package ckhc_pkg;

  localparam int unsigned SET_DEPTH = 4096;
  localparam int unsigned SET_AW    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned USED_W    = SET_AW + 1;
  localparam int unsigned KLEN_W    = 6;
  localparam int unsigned KMER_W    = 64;
  localparam int unsigned KMER_MAX  = 32;
  localparam int unsigned KLEN_RST  = 21;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_INS_A = 2'd0,
    ACT_INS_B = 2'd1,
    ACT_BASE  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_FIN  = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [KMER_W-1:0] kmer_value;
    logic [1:0]        base_code;
    logic              read_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] hap_a_hits;
    logic [31:0] hap_b_hits;
    logic        set_overflow;
  } out_item_t;

  // One queued operation from front to back.
  typedef struct packed {
    logic              is_insert;
    logic              set_b;
    logic              do_lookup;
    logic              last;
    logic [KMER_W-1:0] value;
  } op_t;

endpackage

@@ hw/rtl/ckhc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ckhc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/ckhc_queue.sv @@
// Two-entry word queue between front and back.
// Depends on ckhc_pkg.
module ckhc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ckhc_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output ckhc_pkg::op_t pop_op
);
  import ckhc_pkg::*;

  op_t        slot_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != 2'd0);
  assign pop_op    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) (push && !pop) |=> cnt_r != 2'd0)
    else $error("queue count lost a word");
endmodule

@@ hw/rtl/ckhc_front.sv @@
// Front end: accepts items, holds the k-mer length, the base window and the
// canonical k-mer logic, and turns each item other than ACT_NONE into a queued operation.
// Depends on ckhc_pkg.
module ckhc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  ckhc_pkg::in_item_t item,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_len,
  output logic               push,
  output ckhc_pkg::op_t      push_op
);
  import ckhc_pkg::*;

  logic [KLEN_W-1:0] klen_r;
  logic [KMER_W-1:0] win_r, win_nxt;
  logic [5:0]        seen_r, seen_nxt;
  logic [KLEN_W-1:0] k;
  logic [6:0]        top_sh;
  logic [KMER_W-1:0] mask, rc_full, rc, key_f, key_r, canon;

  always_comb begin
    if (klen_r == '0) begin
      k = KLEN_W'(1);
    end else if (klen_r > KLEN_W'(KMER_MAX)) begin
      k = KLEN_W'(KMER_MAX);
    end else begin
      k = klen_r;
    end
    top_sh = {k, 1'b0} - 7'd2;
    mask   = (k == KLEN_W'(KMER_MAX)) ? '1 : ((KMER_W'(1) << {k, 1'b0}) - KMER_W'(1));
    win_nxt  = ((win_r >> 2) | (KMER_W'(item.base_code) << top_sh)) & mask;
    seen_nxt = (seen_r == 6'd63) ? seen_r : seen_r + 6'd1;
    // Reverse complement: complement pairs in reverse order, then drop padding.
    for (int i = 0; i < KMER_MAX; i++) begin
      rc_full[2*i +: 2] = ~win_nxt[2*(KMER_MAX-1-i) +: 2];
    end
    rc = rc_full >> (7'd64 - {k, 1'b0});
    // First base is most significant in the compare key.
    for (int i = 0; i < KMER_MAX; i++) begin
      key_f[2*i +: 2] = win_nxt[2*(KMER_MAX-1-i) +: 2];
      key_r[2*i +: 2] = rc[2*(KMER_MAX-1-i) +: 2];
    end
    canon = (key_f < key_r) ? win_nxt : rc;
  end

  always_comb begin
    push              = accept && (item.action != ACT_NONE);
    push_op.is_insert = item.action inside {ACT_INS_A, ACT_INS_B};
    push_op.set_b     = (item.action == ACT_INS_B);
    push_op.do_lookup = (item.action == ACT_BASE) && ({2'b00, seen_nxt} >= {2'b00, k});
    push_op.last      = (item.action == ACT_BASE) && item.read_end;
    push_op.value     = push_op.is_insert ? item.kmer_value : canon;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KLEN_W'(KLEN_RST);
      win_r  <= '0;
      seen_r <= '0;
    end else begin
      if (cfg_we) begin
        klen_r <= cfg_len;
      end
      if (accept && item.action == ACT_BASE) begin
        win_r  <= item.read_end ? '0 : win_nxt;
        seen_r <= item.read_end ? '0 : seen_nxt;
      end
    end
  end
endmodule

@@ hw/rtl/ckhc_back.sv @@
// Back end: scans both k-mer sets, applies inserts, keeps hit counts and
// issues results. Depends on ckhc_pkg and ckhc_ram.
module ckhc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ckhc_pkg::op_t        q_op,
  output logic                 pop,
  output logic                 out_valid,
  output ckhc_pkg::out_item_t  out_result
);
  import ckhc_pkg::*;

  back_state_t      state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [USED_W-1:0] idx_r, idx_nxt, pidx_r, pidx_nxt, limit_r, limit_nxt;
  logic [USED_W-1:0] used_a_r, used_a_nxt, used_b_r, used_b_nxt;
  logic             pend_r, pend_nxt;
  logic             hit_a_r, hit_a_nxt, hit_b_r, hit_b_nxt;
  logic [31:0]      cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic             we_a, we_b;
  logic [KMER_W-1:0] rdata_a, rdata_b;

  ckhc_ram #(.WIDTH(KMER_W), .DEPTH(SET_DEPTH)) u_set_a (
    .clk(clk), .we(we_a), .waddr(used_a_r[SET_AW-1:0]), .wdata(op_r.value),
    .raddr(idx_r[SET_AW-1:0]), .rdata(rdata_a)
  );
  ckhc_ram #(.WIDTH(KMER_W), .DEPTH(SET_DEPTH)) u_set_b (
    .clk(clk), .we(we_b), .waddr(used_b_r[SET_AW-1:0]), .wdata(op_r.value),
    .raddr(idx_r[SET_AW-1:0]), .rdata(rdata_b)
  );

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    limit_nxt     = limit_r;
    pend_nxt      = 1'b0;
    hit_a_nxt     = hit_a_r;
    hit_b_nxt     = hit_b_r;
    used_a_nxt    = used_a_r;
    used_b_nxt    = used_b_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    we_a          = 1'b0;
    we_b          = 1'b0;

    // Compare the word read last cycle.
    if (pend_r) begin
      if (pidx_r < used_a_r && rdata_a == op_r.value) hit_a_nxt = 1'b1;
      if (pidx_r < used_b_r && rdata_b == op_r.value) hit_b_nxt = 1'b1;
    end

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          op_nxt    = q_op;
          idx_nxt   = '0;
          hit_a_nxt = 1'b0;
          hit_b_nxt = 1'b0;
          if (q_op.is_insert) begin
            limit_nxt = q_op.set_b ? used_b_r : used_a_r;
          end else if (q_op.do_lookup) begin
            limit_nxt = (used_a_r > used_b_r) ? used_a_r : used_b_r;
          end else begin
            limit_nxt = '0;
          end
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (idx_r < limit_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + USED_W'(1);
        end else begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        state_nxt = BK_IDLE;
        if (op_r.is_insert) begin
          if (!op_r.set_b && !hit_a_r) begin
            if (used_a_r < USED_W'(SET_DEPTH)) begin
              we_a       = 1'b1;
              used_a_nxt = used_a_r + USED_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (op_r.set_b && !hit_b_r) begin
            if (used_b_r < USED_W'(SET_DEPTH)) begin
              we_b       = 1'b1;
              used_b_nxt = used_b_r + USED_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end else begin
          if (op_r.do_lookup && hit_a_r && cnt_a_r != '1) cnt_a_nxt = cnt_a_r + 32'd1;
          if (op_r.do_lookup && hit_b_r && cnt_b_r != '1) cnt_b_nxt = cnt_b_r + 32'd1;
          if (op_r.last) begin
            out_valid_nxt        = 1'b1;
            out_nxt.hap_a_hits   = cnt_a_nxt;
            out_nxt.hap_b_hits   = cnt_b_nxt;
            out_nxt.set_overflow = ovf_r;
            cnt_a_nxt            = '0;
            cnt_b_nxt            = '0;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pend_r      <= 1'b0;
      used_a_r    <= '0;
      used_b_r    <= '0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      used_a_r    <= used_a_nxt;
      used_b_r    <= used_b_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r    <= op_nxt;
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    limit_r <= limit_nxt;
    hit_a_r <= hit_a_nxt;
    hit_b_r <= hit_b_nxt;
    out_r   <= out_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    used_a_r <= USED_W'(SET_DEPTH) && used_b_r <= USED_W'(SET_DEPTH))
    else $error("set fill count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == BK_FIN))
    else $error("result issued outside finish step");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> state_r == BK_IDLE)
    else $error("word taken while back end busy");
  assert property (@(posedge clk) disable iff (!rst_n) $rose(ovf_r) |-> $past(op_r.is_insert))
    else $error("overflow raised by a lookup");
endmodule

@@ hw/rtl/canonical_kmer_haplotype_counter.sv @@
// Canonical k-mer haplotype counter, top level.
// Depends on ckhc_pkg, ckhc_front, ckhc_queue and ckhc_back.
//
// An item is taken when start is high and busy is low. Inserts look for a
// duplicate in the chosen set, then append; a base is looked up in both sets
// once k bases of its read have been seen. Each back-end operation scans the
// valid entries (the fill count of the set for an insert, the larger fill
// count of the two sets for a lookup), one set entry per cycle through a
// single read port of each set memory. A two-word queue lets the front take
// up to two items ahead of the back end; busy is high while it is full. A
// result for a base that ends a read appears on out_result with out_valid
// high for one cycle, registered from the finish state; it cannot be stalled.
// The set memories are not cleared after reset; fill counts gate every compare.
module canonical_kmer_haplotype_counter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ckhc_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ckhc_pkg::out_item_t out_result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);
  import ckhc_pkg::*;

  logic accept, push, full, pop, q_valid;
  op_t  push_op, q_op;

  assign busy      = full;
  assign accept    = start && !full;
  assign cfg_ready = 1'b1;

  ckhc_front u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .item(in_item),
    .cfg_we(cfg_valid), .cfg_len(cfg_data), .push(push), .push_op(push_op)
  );

  ckhc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_op(push_op), .full(full),
    .pop(pop), .not_empty(q_valid), .pop_op(q_op)
  );

  ckhc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_op(q_op), .pop(pop),
    .out_valid(out_valid), .out_result(out_result)
  );
endmodule
